FILE: rtl/lbtc_pkg.sv
package lbtc_pkg;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_IRQ  = 2'd2;

	localparam logic [1:0] MODE_RX   = 2'd0;
	localparam logic [1:0] MODE_SCAN = 2'd1;
	localparam logic [1:0] MODE_TX   = 2'd2;

	localparam logic [7:0] MAX_FRAME    = 8'd255;
	localparam logic [7:0] BACKOFF_BASE = 8'd20;

	typedef struct packed {
		logic [1:0] op;
		logic [8:0] frame_len;
		logic [6:0] jitter;
		logic       scan_busy;
		logic       scan_start_ok;
		logic       tx_start_ok;
		logic       rx_ok;
		logic [8:0] rx_len;
	} in_word_t;

	typedef struct packed {
		logic        send_accepted;
		logic        cmd_scan;
		logic        cmd_transmit;
		logic        cmd_receive;
		logic [1:0]  mode;
		logic [7:0]  out_len;
		logic        rx_deliver;
		logic [31:0] tx_total;
		logic [31:0] rx_total;
		logic [31:0] rx_err_total;
		logic [31:0] busy_total;
		logic [31:0] forced_total;
	} out_word_t;

	typedef struct packed {
		logic [1:0]  cur_mode;
		logic [7:0]  parked_len;
		logic [2:0]  try_count;
		logic [15:0] backoff_left;
		logic [31:0] tx_counter;
		logic [31:0] rx_counter;
		logic [31:0] rx_err_counter;
		logic [31:0] busy_counter;
		logic [31:0] forced_counter;
	} lbtc_state_t;

endpackage

FILE: rtl/lbtc_step.sv
module lbtc_step #(
	parameter int MAX_TRIES = 4
) (
	input  lbtc_pkg::lbtc_state_t st,
	input  lbtc_pkg::in_word_t    word,
	input  logic                  scan_enable,
	output lbtc_pkg::lbtc_state_t st_nx,
	output lbtc_pkg::out_word_t   res
);
	import lbtc_pkg::*;

	localparam logic [3:0] TRY_LIMIT = 4'(MAX_TRIES);

	logic        f_scan;
	logic        f_tx;
	logic        f_rx;
	logic        f_deliver;
	logic        accepted;
	logic [7:0]  f_len;
	logic        do_scan;
	logic        do_tx;
	logic        send_ok;
	logic        retry;
	logic [7:0]  backoff_base;
	logic [7:0]  rx_len_c;

	assign send_ok = (st.cur_mode == MODE_RX) && (st.parked_len == 8'd0)
		&& (word.frame_len != 9'd0) && (word.frame_len <= {1'b0, MAX_FRAME});
	assign retry = word.scan_busy && (({1'b0, st.try_count} + 4'd1) < TRY_LIMIT);
	assign backoff_base = BACKOFF_BASE + {1'b0, word.jitter};
	assign rx_len_c = (word.rx_len > {1'b0, MAX_FRAME}) ? MAX_FRAME : word.rx_len[7:0];

	always_comb begin
		st_nx     = st;
		f_scan    = 1'b0;
		f_tx      = 1'b0;
		f_rx      = 1'b0;
		f_deliver = 1'b0;
		f_len     = 8'd0;
		accepted  = 1'b0;
		do_scan   = 1'b0;
		do_tx     = 1'b0;
		unique case (word.op)
			OP_SEND: begin
				if (send_ok) begin
					accepted         = 1'b1;
					st_nx.parked_len = word.frame_len[7:0];
					st_nx.try_count  = 3'd0;
					if (scan_enable) begin
						do_scan = 1'b1;
					end else begin
						do_tx = 1'b1;
					end
				end
			end
			OP_TICK: begin
				if (st.cur_mode == MODE_RX && st.parked_len != 8'd0) begin
					if (st.backoff_left <= 16'd1) begin
						st_nx.backoff_left = 16'd0;
						do_scan = 1'b1;
					end else begin
						st_nx.backoff_left = st.backoff_left - 16'd1;
					end
				end
			end
			OP_IRQ: begin
				if (st.cur_mode == MODE_TX) begin
					st_nx.tx_counter = st.tx_counter + 32'd1;
					st_nx.cur_mode   = MODE_RX;
					f_rx = 1'b1;
				end else if (st.cur_mode == MODE_SCAN) begin
					if (retry) begin
						st_nx.busy_counter = st.busy_counter + 32'd1;
						st_nx.try_count    = st.try_count + 3'd1;
						st_nx.backoff_left = {8'd0, backoff_base} << st.try_count;
						st_nx.cur_mode     = MODE_RX;
						f_rx = 1'b1;
					end else begin
						if (word.scan_busy) begin
							st_nx.busy_counter   = st.busy_counter + 32'd1;
							st_nx.forced_counter = st.forced_counter + 32'd1;
						end
						do_tx = 1'b1;
					end
				end else begin
					if (word.rx_ok) begin
						st_nx.rx_counter = st.rx_counter + 32'd1;
						f_deliver = 1'b1;
						f_len     = rx_len_c;
					end else begin
						st_nx.rx_err_counter = st.rx_err_counter + 32'd1;
					end
					st_nx.cur_mode = MODE_RX;
					f_rx = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_scan) begin
			st_nx.cur_mode = MODE_SCAN;
			f_scan = 1'b1;
			if (!word.scan_start_ok) begin
				do_tx = 1'b1;
			end
		end
		if (do_tx) begin
			f_tx  = 1'b1;
			f_len = st_nx.parked_len;
			st_nx.parked_len = 8'd0;
			if (word.tx_start_ok) begin
				st_nx.cur_mode = MODE_TX;
			end else begin
				st_nx.cur_mode = MODE_RX;
				f_rx = 1'b1;
			end
		end
	end

	always_comb begin
		res.send_accepted = accepted;
		res.cmd_scan      = f_scan;
		res.cmd_transmit  = f_tx;
		res.cmd_receive   = f_rx;
		res.mode          = st_nx.cur_mode;
		res.out_len       = f_len;
		res.rx_deliver    = f_deliver;
		res.tx_total      = st_nx.tx_counter;
		res.rx_total      = st_nx.rx_counter;
		res.rx_err_total  = st_nx.rx_err_counter;
		res.busy_total    = st_nx.busy_counter;
		res.forced_total  = st_nx.forced_counter;
	end

endmodule

FILE: rtl/lbt_csma_transmit_controller.sv
// channel   direction  handshake            word
// in        input      in_valid/in_ready    in_data  (op, lengths, radio status)
// out       output     out_valid/out_ready  out_data (commands, mode, totals)
// cfg       input      cfg_we               cfg_wdata (scan_enable)
//
// One word per cycle sustained while the output is not stalled; a word goes from input to output
// through the input register, then through the step logic into the output register.
// Controller state updates when a word moves from the input to the output register.
// Reset clears mode, parked frame, backoff and all totals; scan_enable resets to 1.
// A stalled output holds its word; the input register takes one more word, then input stalls.
module lbt_csma_transmit_controller #(
	parameter int MAX_TRIES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lbtc_pkg::in_word_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lbtc_pkg::out_word_t  out_data,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);
	import lbtc_pkg::*;

	logic        in_valid_s1;
	in_word_t    in_data_s1;
	logic        out_valid_q;
	out_word_t   out_data_q;
	logic        scan_enable_q;
	lbtc_state_t st_q;
	lbtc_state_t st_nx;
	out_word_t   res;
	logic        advance;

	assign advance  = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	lbtc_step #(
		.MAX_TRIES(MAX_TRIES)
	) u_step (
		.st          (st_q),
		.word        (in_data_s1),
		.scan_enable (scan_enable_q),
		.st_nx       (st_nx),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q <= 1'b1;
		end else if (cfg_we) begin
			scan_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_tx_nothing_parked: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cur_mode == MODE_TX |-> st_q.parked_len == 8'd0)
		else $error("transmitting with a frame still parked");

	a_scan_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.cur_mode == MODE_SCAN |-> st_q.parked_len != 8'd0)
		else $error("scanning with no frame parked");

	a_try_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, st_q.try_count} < 4'(MAX_TRIES))
		else $error("try count beyond limit");

	a_accept_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.send_accepted
		|-> out_data_q.cmd_scan || out_data_q.cmd_transmit)
		else $error("accepted send issued no command");

	a_tx_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> st_q.tx_counter == $past(st_q.tx_counter)
			|| st_q.tx_counter == $past(st_q.tx_counter) + 32'd1)
		else $error("tx total jumped");

endmodule
